>>> rtl/hsv2rgb_pkg.sv
`default_nettype none
package hsv2rgb_pkg;

	localparam int HUE_W    = 9;
	localparam int CFG_W    = 9;
	localparam int CH_W     = 8;
	localparam int PACK_W   = 3 * CH_W;
	localparam int APB_DW   = 32;
	localparam int APB_AW   = 3;
	localparam int SECTOR_DEG = 60;

	localparam logic [CFG_W-1:0] Q_ONE    = 9'd256;
	localparam logic [HUE_W-1:0] HUE_WRAP = 9'd360;

	localparam logic [CFG_W-1:0] SAT_RESET = 9'd256;
	localparam logic [CFG_W-1:0] BRI_RESET = 9'd38;

	// register index, taken from paddr[2]
	localparam logic REG_SAT = 1'b0;
	localparam logic REG_BRI = 1'b1;

	// red-yellow, yellow-green, green-cyan, cyan-blue, blue-magenta, magenta-red
	typedef enum logic [2:0] {
		SECT_RY,
		SECT_YG,
		SECT_GC,
		SECT_CB,
		SECT_BM,
		SECT_MR
	} sector_t;

	typedef struct packed {
		logic [CFG_W-1:0] sat;
		logic [CFG_W-1:0] bri;
	} cfg_t;

	typedef struct packed {
		logic    black;
		sector_t sector;
	} tag_t;

	function automatic logic [CFG_W-1:0] clamp_q18(input logic [CFG_W-1:0] x);
		return (x > Q_ONE) ? Q_ONE : x;
	endfunction

endpackage
`default_nettype wire

>>> rtl/hsv2rgb_if.sv
`default_nettype none
interface hue_if;
	logic                           valid;
	logic                           ready;
	logic [hsv2rgb_pkg::HUE_W-1:0]  hue_degrees;

	modport source (output valid, output hue_degrees, input ready);
	modport sink (input valid, input hue_degrees, output ready);
endinterface

interface rgb_if;
	logic                            valid;
	logic                            ready;
	logic [hsv2rgb_pkg::CH_W-1:0]    red;
	logic [hsv2rgb_pkg::CH_W-1:0]    green;
	logic [hsv2rgb_pkg::CH_W-1:0]    blue;
	logic [hsv2rgb_pkg::PACK_W-1:0]  packed_color;

	modport source (output valid, output red, output green, output blue,
		output packed_color, input ready);
	modport sink (input valid, input red, input green, input blue,
		input packed_color, output ready);
endinterface
`default_nettype wire

>>> rtl/hsv2rgb_cfg.sv
`default_nettype none
module hsv2rgb_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [hsv2rgb_pkg::APB_AW-1:0]   paddr,
	input  wire logic [hsv2rgb_pkg::APB_DW-1:0]   pwdata,
	output logic      [hsv2rgb_pkg::APB_DW-1:0]   prdata,
	output logic                                  pready,
	output hsv2rgb_pkg::cfg_t                     cfg
);
	import hsv2rgb_pkg::*;

	logic [CFG_W-1:0] sat_q;
	logic [CFG_W-1:0] bri_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= SAT_RESET;
			bri_q <= BRI_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_SAT: sat_q <= pwdata[CFG_W-1:0];
				REG_BRI: bri_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_SAT: prdata = APB_DW'(sat_q);
			REG_BRI: prdata = APB_DW'(bri_q);
			default: prdata = '0;
		endcase
	end

	assign cfg.sat = clamp_q18(sat_q);
	assign cfg.bri = clamp_q18(bri_q);

	a_wr_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && paddr[2] == REG_SAT) |=> (sat_q == $past(pwdata[CFG_W-1:0])))
		else $error("saturation write not taken");

endmodule
`default_nettype wire

>>> rtl/hsv2rgb_sector.sv
`default_nettype none
module hsv2rgb_sector (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire hsv2rgb_pkg::cfg_t     cfg,
	hue_if.sink                        hue_in,
	output logic                       valid_s1,
	input  wire logic                  ready_next,
	output hsv2rgb_pkg::tag_t          tag_s1,
	output logic [5:0]                 rem_s1
);
	import hsv2rgb_pkg::*;

	logic [HUE_W-1:0] h;
	sector_t          sector;
	logic [5:0]       rem;
	logic             black;
	logic             en_s1;

	assign hue_in.ready = !valid_s1 || ready_next;
	assign en_s1        = hue_in.valid && hue_in.ready;

	// 360 wraps to 0; above 360 is black unless sat is 0; any sector will do
	assign h     = (hue_in.hue_degrees >= HUE_WRAP) ? '0 : hue_in.hue_degrees;
	assign black = (hue_in.hue_degrees > HUE_WRAP) && (cfg.sat != '0);

	always_comb begin
		if (h < HUE_W'(SECTOR_DEG)) begin
			sector = SECT_RY;
			rem    = h[5:0];
		end else if (h < HUE_W'(2 * SECTOR_DEG)) begin
			sector = SECT_YG;
			rem    = 6'(h - HUE_W'(SECTOR_DEG));
		end else if (h < HUE_W'(3 * SECTOR_DEG)) begin
			sector = SECT_GC;
			rem    = 6'(h - HUE_W'(2 * SECTOR_DEG));
		end else if (h < HUE_W'(4 * SECTOR_DEG)) begin
			sector = SECT_CB;
			rem    = 6'(h - HUE_W'(3 * SECTOR_DEG));
		end else if (h < HUE_W'(5 * SECTOR_DEG)) begin
			sector = SECT_BM;
			rem    = 6'(h - HUE_W'(4 * SECTOR_DEG));
		end else begin
			sector = SECT_MR;
			rem    = 6'(h - HUE_W'(5 * SECTOR_DEG));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (hue_in.ready) begin
			valid_s1 <= hue_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			tag_s1.black  <= black;
			tag_s1.sector <= sector;
			rem_s1        <= rem;
		end
	end

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		en_s1 |=> (rem_s1 < 6'(SECTOR_DEG)) && (tag_s1.sector <= SECT_MR))
		else $error("sector split out of range");

endmodule
`default_nettype wire

>>> rtl/hsv2rgb_mul.sv
`default_nettype none
module hsv2rgb_mul #(
	parameter int FB = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire hsv2rgb_pkg::cfg_t     cfg,
	input  wire logic                  valid_s1,
	output logic                       ready_s1,
	input  wire hsv2rgb_pkg::tag_t     tag_s1,
	input  wire logic [5:0]            rem_s1,
	output logic                       valid_s4,
	input  wire logic                  ready_next,
	output hsv2rgb_pkg::tag_t          tag_s4,
	output logic [17:0]                a_s4,
	output logic [17+FB:0]             b_s4,
	output logic [17+FB:0]             c_s4
);
	import hsv2rgb_pkg::*;

	localparam int NW = 9 + FB;
	localparam logic [NW-1:0] FULL = NW'(1) << (8 + FB);
	localparam logic [FB:0]   ONE  = (FB+1)'(1) << FB;

	typedef logic [FB-1:0] fq_tab_t [64];

	function automatic fq_tab_t build_fq_tab();
		fq_tab_t t;
		for (int i = 0; i < 64; i++) begin
			t[i] = (i < SECTOR_DEG) ? FB'((i << FB) / SECTOR_DEG) : '0;
		end
		return t;
	endfunction

	localparam fq_tab_t FqTab = build_fq_tab();

	logic          valid_s2, valid_s3;
	logic          ready_s2, ready_s3, ready_s4;
	tag_t          tag_s2, tag_s3;
	logic [FB-1:0] fq_s2;
	logic [FB:0]   ofq_s2;
	logic [17:0]   a_s2, a_s3;
	logic [NW-1:0] nb_s3, nc_s3;
	logic [NW-1:0] sfq, sofq;

	assign ready_s4 = !valid_s4 || ready_next;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = ready_s2;

	assign sfq  = NW'(cfg.sat) * NW'(fq_s2);
	assign sofq = NW'(cfg.sat) * NW'(ofq_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
		end
	end

	// fraction lookup and the A product
	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			tag_s2 <= tag_s1;
			fq_s2  <= FqTab[rem_s1];
			ofq_s2 <= ONE - (FB+1)'(FqTab[rem_s1]);
			a_s2   <= 18'(cfg.bri) * 18'(Q_ONE - cfg.sat);
		end
	end

	// 1 - S*f and 1 - S*(1-f), scaled by 256*one
	always_ff @(posedge clk) begin
		if (valid_s2 && ready_s3) begin
			tag_s3 <= tag_s2;
			a_s3   <= a_s2;
			nb_s3  <= FULL - sfq;
			nc_s3  <= FULL - sofq;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3 && ready_s4) begin
			tag_s4 <= tag_s3;
			a_s4   <= a_s3;
			b_s4   <= (18 + FB)'(cfg.bri) * (18 + FB)'(nb_s3);
			c_s4   <= (18 + FB)'(cfg.bri) * (18 + FB)'(nc_s3);
		end
	end

	a_hold_s4: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && !ready_next) |=> (valid_s4 && $stable(b_s4) && $stable(c_s4)))
		else $error("stalled products changed");

endmodule
`default_nettype wire

>>> rtl/hsv2rgb_out.sv
`default_nettype none
module hsv2rgb_out #(
	parameter int FB = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire hsv2rgb_pkg::cfg_t     cfg,
	input  wire logic                  valid_s4,
	output logic                       ready_s4,
	input  wire hsv2rgb_pkg::tag_t     tag_s4,
	input  wire logic [17:0]           a_s4,
	input  wire logic [17+FB:0]        b_s4,
	input  wire logic [17+FB:0]        c_s4,
	rgb_if.source                      rgb_out
);
	import hsv2rgb_pkg::*;

	localparam int PW = 18 + FB;

	logic            valid_s5;
	logic            en_s5;
	logic [CH_W-1:0] red_s5, green_s5, blue_s5;
	logic [16:0]     v_x;
	logic [25:0]     a_x;
	logic [PW+7:0]   b_x, c_x;
	logic [CH_W-1:0] v_ch, a_ch, b_ch, c_ch;
	logic [CH_W-1:0] r, g, b;

	assign ready_s4 = !valid_s5 || rgb_out.ready;
	assign en_s5    = valid_s4 && ready_s4;

	// x*255 as (x<<8)-x, then drop the fraction bits
	assign v_x  = (17'(cfg.bri) << 8) - 17'(cfg.bri);
	assign a_x  = (26'(a_s4) << 8) - 26'(a_s4);
	assign b_x  = ((PW+8)'(b_s4) << 8) - (PW+8)'(b_s4);
	assign c_x  = ((PW+8)'(c_s4) << 8) - (PW+8)'(c_s4);
	assign v_ch = v_x[15:8];
	assign a_ch = a_x[23:16];
	assign b_ch = b_x[FB+23:FB+16];
	assign c_ch = c_x[FB+23:FB+16];

	always_comb begin
		case (tag_s4.sector)
			SECT_RY: begin r = v_ch; g = c_ch; b = a_ch; end
			SECT_YG: begin r = b_ch; g = v_ch; b = a_ch; end
			SECT_GC: begin r = a_ch; g = v_ch; b = c_ch; end
			SECT_CB: begin r = a_ch; g = b_ch; b = v_ch; end
			SECT_BM: begin r = c_ch; g = a_ch; b = v_ch; end
			SECT_MR: begin r = v_ch; g = a_ch; b = b_ch; end
			default: begin r = v_ch; g = a_ch; b = b_ch; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (ready_s4) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			red_s5   <= tag_s4.black ? '0 : r;
			green_s5 <= tag_s4.black ? '0 : g;
			blue_s5  <= tag_s4.black ? '0 : b;
		end
	end

	assign rgb_out.valid        = valid_s5;
	assign rgb_out.red          = red_s5;
	assign rgb_out.green        = green_s5;
	assign rgb_out.blue         = blue_s5;
	assign rgb_out.packed_color = {red_s5, green_s5, blue_s5};

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		(en_s5 && tag_s4.black) |=> (valid_s5 && red_s5 == '0 && green_s5 == '0
			&& blue_s5 == '0))
		else $error("out-of-range hue not black");

endmodule
`default_nettype wire

>>> rtl/hsv_to_rgb_converter.sv
`default_nettype none
// HSV to RGB converter. Each item is a hue in whole degrees; saturation and
// brightness come from two APB registers in Q1.8 (256 = 1.0, larger values
// clamp to 1.0), at byte addresses 0 and 4. Write them only while no item is
// in flight. One item is accepted per clock while rgb_out is not stalled; a
// result passes a five-stage pipeline: sector split, fraction lookup, the
// 1-S*f terms, the brightness multiplies, and channel scaling with the output
// register. Each stage holds its item under back-pressure and takes a new
// one whenever it is empty or draining, so bubbles close up during a stall.
// Hue 360 wraps to 0; a hue above 360 gives black unless saturation is zero.
module hsv_to_rgb_converter #(
	parameter int FRACTION_BITS = 8
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [hsv2rgb_pkg::APB_AW-1:0]   paddr,
	input  wire logic [hsv2rgb_pkg::APB_DW-1:0]   pwdata,
	output logic      [hsv2rgb_pkg::APB_DW-1:0]   prdata,
	output logic                                  pready,
	hue_if.sink                                   hue_in,
	rgb_if.source                                 rgb_out
);
	import hsv2rgb_pkg::*;

	cfg_t                     cfg;
	logic                     valid_s1, ready_s1;
	tag_t                     tag_s1;
	logic [5:0]               rem_s1;
	logic                     valid_s4, ready_s4;
	tag_t                     tag_s4;
	logic [17:0]              a_s4;
	logic [17+FRACTION_BITS:0] b_s4, c_s4;

	hsv2rgb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	hsv2rgb_sector u_sector (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.hue_in     (hue_in),
		.valid_s1   (valid_s1),
		.ready_next (ready_s1),
		.tag_s1     (tag_s1),
		.rem_s1     (rem_s1)
	);

	hsv2rgb_mul #(
		.FB (FRACTION_BITS)
	) u_mul (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.valid_s1   (valid_s1),
		.ready_s1   (ready_s1),
		.tag_s1     (tag_s1),
		.rem_s1     (rem_s1),
		.valid_s4   (valid_s4),
		.ready_next (ready_s4),
		.tag_s4     (tag_s4),
		.a_s4       (a_s4),
		.b_s4       (b_s4),
		.c_s4       (c_s4)
	);

	hsv2rgb_out #(
		.FB (FRACTION_BITS)
	) u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_s4 (valid_s4),
		.ready_s4 (ready_s4),
		.tag_s4   (tag_s4),
		.a_s4     (a_s4),
		.b_s4     (b_s4),
		.c_s4     (c_s4),
		.rgb_out  (rgb_out)
	);

endmodule
`default_nettype wire
